/* sv/wre_pkg.sv */
// Shared types and constants for the windowed RMS envelope block.
`default_nettype none

package wre_pkg;

    // Width of the amplitude field on the result port.
    localparam int AMP_W = 12;

    // Markers that travel with each result.
    typedef struct packed {
        logic run_last;
        logic scan_end;
    } t_flags;

endpackage

`default_nettype wire

/* sv/windowed_rms_envelope.sv */
// Top level: moving-window RMS envelope of one ADC scan with integer square root.
// Each sample is taken only in the idle state, so no new sample enters while the results of the
// previous one are summed or handed to the root; a last sample flushes the remaining positions.
// Reset (synchronous, active low) clears the sample count and all handshake state; the sample
// window is not cleared, as each scan writes an entry before it is read.
`default_nettype none

module windowed_rms_envelope #(
    parameter int WINDOW      = 8,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [SAMPLE_BITS-1:0]       i_sample,
    input  logic                         i_is_last,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [wre_pkg::AMP_W-1:0]    o_amplitude,
    output logic                         o_run_last,
    output logic                         o_scan_end
);

    import wre_pkg::*;

    localparam int AW   = $clog2(WINDOW);
    localparam int SUMW = 2 * SAMPLE_BITS - 1 + $clog2(WINDOW);

    logic                   wr_en;
    logic [AW-1:0]          rd_idx;
    logic [SAMPLE_BITS-1:0] rd_mag;
    logic                   job_vld;
    logic                   job_rdy;
    logic [SUMW-1:0]        job_sum;
    t_flags                 job_flags;
    t_flags                 out_flags;

    wre_window #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_data (i_sample),
        .i_rd_idx  (rd_idx),
        .o_rd_mag  (rd_mag)
    );

    wre_accum #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_is_last   (i_is_last),
        .o_wr_en     (wr_en),
        .o_rd_idx    (rd_idx),
        .i_rd_mag    (rd_mag),
        .o_job_vld   (job_vld),
        .i_job_rdy   (job_rdy),
        .o_job_sum   (job_sum),
        .o_job_flags (job_flags)
    );

    wre_root #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_root (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_vld   (job_vld),
        .o_job_rdy   (job_rdy),
        .i_job_sum   (job_sum),
        .i_job_flags (job_flags),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_amplitude (o_amplitude),
        .o_out_flags (out_flags)
    );

    assign o_run_last = out_flags.run_last;
    assign o_scan_end = out_flags.scan_end;

    // A finished window sum must wait, unchanged, until the root unit takes it.
    a_job_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_vld && !job_rdy |=> job_vld && $stable(job_sum))
        else $error("window sum changed before transfer to the root unit");

    // A new sample must never shift the window while a sum is still awaiting hand-off.
    a_in_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |-> !job_vld)
        else $error("sample taken while a window sum was pending");

    a_job_flags : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_vld && job_flags.scan_end |-> job_flags.run_last)
        else $error("scan end marked on a result that does not close its item");

    a_out_flags : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_scan_end |-> o_run_last)
        else $error("scan end without run last on the result port");

endmodule

`default_nettype wire

/* sv/wre_window.sv */
// Sample shift line, newest first, with one read port that returns the centred magnitude.
`default_nettype none

module wre_window #(
    parameter int WINDOW      = 8,
    parameter int SAMPLE_BITS = 12,
    localparam int AW         = $clog2(WINDOW)
) (
    input  logic                   i_clk,
    input  logic                   i_wr_en,
    input  logic [SAMPLE_BITS-1:0] i_wr_data,
    input  logic [AW-1:0]          i_rd_idx,
    output logic [SAMPLE_BITS-1:0] o_rd_mag
);

    localparam logic [SAMPLE_BITS-1:0] MID = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [SAMPLE_BITS-1:0] r_taps [WINDOW];
    logic [SAMPLE_BITS-1:0] rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_taps[0] <= i_wr_data;
            for (int k = 1; k < WINDOW; k++) begin
                r_taps[k] <= r_taps[k-1];
            end
        end
    end

    assign rd_data  = r_taps[i_rd_idx];
    // Distance from mid-scale; the top bit tells which side of it the sample lies.
    assign o_rd_mag = rd_data[SAMPLE_BITS-1] ? (rd_data - MID) : (MID - rd_data);

endmodule

`default_nettype wire

/* sv/wre_accum.sv */
// Result sequencer and sum-of-squares accumulator over one window per result.
`default_nettype none

module wre_accum #(
    parameter int WINDOW      = 8,
    parameter int SAMPLE_BITS = 12,
    localparam int AW         = $clog2(WINDOW),
    localparam int SUMW       = 2 * SAMPLE_BITS - 1 + $clog2(WINDOW)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_is_last,
    output logic                   o_wr_en,
    output logic [AW-1:0]          o_rd_idx,
    input  logic [SAMPLE_BITS-1:0] i_rd_mag,
    output logic                   o_job_vld,
    input  logic                   i_job_rdy,
    output logic [SUMW-1:0]        o_job_sum,
    output wre_pkg::t_flags        o_job_flags
);

    import wre_pkg::*;

    localparam int CW   = $clog2(WINDOW + 1);
    localparam int SQW  = 2 * SAMPLE_BITS - 1;

    localparam logic [CW-1:0] WIN_C    = CW'(WINDOW);
    localparam logic [CW-1:0] WIN_M1_C = CW'(WINDOW - 1);
    localparam logic [AW-1:0] HALF_A   = AW'(WINDOW / 2);
    localparam logic [AW-1:0] LAST_J   = AW'(WINDOW - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_HAND  = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_seen, n_seen;
    logic [AW-1:0] r_newest, n_newest;
    logic [AW-1:0] r_q, n_q;
    logic [AW-1:0] r_qend, n_qend;
    logic [AW-1:0] r_j, n_j;
    logic          r_last, n_last;

    logic                   r_v1, r_f1, r_l1;
    logic                   r_v2, r_f2, r_l2;
    logic [SAMPLE_BITS-1:0] r_mag;
    logic [SQW-1:0]         r_sq;
    logic [SUMW-1:0]        r_acc;

    logic                     accept;
    logic [CW-1:0]            seen_inc;
    logic [AW-1:0]            newest;
    logic                     emit;
    logic [AW-1:0]            q_start;
    logic [AW-1:0]            q_end;
    logic [AW:0]              base_w;
    logic [AW-1:0]            base;
    logic [2*SAMPLE_BITS-1:0] sq_full;
    logic                     run_last;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign seen_inc = (r_seen < WIN_C) ? (r_seen + CW'(1)) : r_seen;
    assign newest   = AW'(seen_inc - CW'(1));
    // A full window is reached on the sample that fills it; the last sample flushes.
    assign emit     = (r_seen >= WIN_M1_C) || i_is_last;
    // Once the window has been full before, the leading positions are already out.
    assign q_start  = (r_seen >= WIN_C) ? HALF_A : '0;
    assign q_end    = i_is_last ? newest : HALF_A;

    // Leading positions share the scan's first window; later ones are centred.
    assign base_w = {1'b0, r_newest} - {1'b0, r_q} + {1'b0, HALF_A};
    assign base   = (r_q < HALF_A) ? r_newest : base_w[AW-1:0];

    assign o_rd_idx = (base >= r_j) ? (base - r_j) : '0;

    always_comb begin
        n_state  = r_state;
        n_seen   = r_seen;
        n_newest = r_newest;
        n_q      = r_q;
        n_qend   = r_qend;
        n_last   = r_last;
        n_j      = r_j;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_seen   = i_is_last ? '0 : seen_inc;
                    n_newest = newest;
                    n_q      = q_start;
                    n_qend   = q_end;
                    n_last   = i_is_last;
                    n_j      = '0;
                    if (emit) begin
                        n_state = S_SWEEP;
                    end
                end
            end
            S_SWEEP: begin
                n_j = r_j + AW'(1);
                if (r_j == LAST_J) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_v2 && r_l2) begin
                    n_state = S_HAND;
                end
            end
            S_HAND: begin
                if (i_job_rdy) begin
                    if (r_q == r_qend) begin
                        n_state = S_IDLE;
                    end else begin
                        n_q     = r_q + AW'(1);
                        n_j     = '0;
                        n_state = S_SWEEP;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_seen   <= '0;
            r_newest <= '0;
            r_q      <= '0;
            r_qend   <= '0;
            r_last   <= 1'b0;
            r_j      <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_seen   <= n_seen;
            r_newest <= n_newest;
            r_q      <= n_q;
            r_qend   <= n_qend;
            r_last   <= n_last;
            r_j      <= n_j;
            r_v1     <= (r_state == S_SWEEP);
            r_v2     <= r_v1;
        end
    end

    assign sq_full = r_mag * r_mag;

    always_ff @(posedge i_clk) begin
        r_f1  <= (r_j == '0);
        r_l1  <= (r_j == LAST_J);
        r_mag <= i_rd_mag;
        r_f2  <= r_f1;
        r_l2  <= r_l1;
        r_sq  <= sq_full[SQW-1:0];
        if (r_v2) begin
            r_acc <= (r_f2 ? '0 : r_acc) + SUMW'(r_sq);
        end
    end

    assign run_last = (r_q == r_qend);

    assign o_in_ready           = (r_state == S_IDLE);
    assign o_wr_en              = accept;
    assign o_job_vld            = (r_state == S_HAND);
    assign o_job_sum            = r_acc;
    assign o_job_flags.run_last = run_last;
    assign o_job_flags.scan_end = run_last && r_last;

endmodule

`default_nettype wire

/* sv/wre_root.sv */
// Digit-serial divide by the window length feeding a bit-per-step square root, with output register.
`default_nettype none

module wre_root #(
    parameter int WINDOW      = 8,
    parameter int SAMPLE_BITS = 12,
    localparam int SUMW       = 2 * SAMPLE_BITS - 1 + $clog2(WINDOW)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_vld,
    output logic                         o_job_rdy,
    input  logic [SUMW-1:0]              i_job_sum,
    input  wre_pkg::t_flags              i_job_flags,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [wre_pkg::AMP_W-1:0]    o_amplitude,
    output wre_pkg::t_flags              o_out_flags
);

    import wre_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int RW   = $clog2(WINDOW);
    localparam int CNTW = $clog2(SB);
    localparam int DVW  = 2 * SB;
    localparam int SRW  = SB + 2;
    localparam int RSW  = SB + 4;

    localparam logic [RW:0]     WIN_R     = (RW + 1)'(WINDOW);
    localparam logic [CNTW-1:0] LAST_STEP = CNTW'(SB - 1);

    logic            r_busy;
    logic            r_ovld;
    logic [CNTW-1:0] r_cnt;
    logic [RW-1:0]   r_rem;
    logic [DVW-1:0]  r_dvd;
    logic [SRW-1:0]  r_srem;
    logic [SB-1:0]   r_root;
    t_flags          r_flags;
    logic [AMP_W-1:0] r_amp;
    t_flags          r_oflags;

    logic            take;
    logic            last_step;
    logic            hold;
    logic            step;
    logic [RW:0]     t1, t2;
    logic            q1, q2;
    logic [RW-1:0]   rem1, rem2;
    logic [RSW-1:0]  rs, trial;
    logic            ge;
    logic [SRW-1:0]  srem_n;
    logic [SB-1:0]   root_n;
    logic [AMP_W-1:0] amp_n;

    // Two restoring division steps give the next two quotient bits, which form
    // the next radicand digit of the square root.
    assign t1   = {r_rem, r_dvd[DVW-1]};
    assign q1   = (t1 >= WIN_R);
    assign rem1 = q1 ? RW'(t1 - WIN_R) : t1[RW-1:0];
    assign t2   = {rem1, r_dvd[DVW-2]};
    assign q2   = (t2 >= WIN_R);
    assign rem2 = q2 ? RW'(t2 - WIN_R) : t2[RW-1:0];

    assign rs     = {r_srem, q1, q2};
    assign trial  = RSW'({r_root, 2'b01});
    assign ge     = (rs >= trial);
    assign srem_n = ge ? SRW'(rs - trial) : SRW'(rs);
    assign root_n = {r_root[SB-2:0], ge};

    if (SB >= AMP_W) begin : g_trunc
        assign amp_n = root_n[AMP_W-1:0];
    end else begin : g_ext
        assign amp_n = {{(AMP_W - SB){1'b0}}, root_n};
    end

    assign take      = i_job_vld && !r_busy;
    assign last_step = r_busy && (r_cnt == LAST_STEP);
    // The final step waits while the previous result has not been transferred.
    assign hold      = last_step && r_ovld && !i_out_ready;
    assign step      = r_busy && !hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ovld <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (take) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (step) begin
                r_cnt <= r_cnt + CNTW'(1);
                if (last_step) begin
                    r_busy <= 1'b0;
                end
            end
            if (step && last_step) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            // The quotient fits in 2*SB bits, so the upper sum bits start the remainder.
            r_rem   <= RW'(i_job_sum >> DVW);
            r_dvd   <= i_job_sum[DVW-1:0];
            r_srem  <= '0;
            r_root  <= '0;
            r_flags <= i_job_flags;
        end else if (step) begin
            r_rem  <= rem2;
            r_dvd  <= r_dvd << 2;
            r_srem <= srem_n;
            r_root <= root_n;
        end
        if (step && last_step) begin
            r_amp    <= amp_n;
            r_oflags <= r_flags;
        end
    end

    assign o_job_rdy   = !r_busy;
    assign o_out_valid = r_ovld;
    assign o_amplitude = r_amp;
    assign o_out_flags = r_oflags;

endmodule

`default_nettype wire
